FILE: rtl/lcrb_pkg.sv
package lcrb_pkg;

  // rate datapath width
  localparam int RATE_BITS = 28;

  // register and field widths
  localparam int REG_W   = 28;
  localparam int TRIP_W  = 8;
  localparam int OUT_W   = 28;
  localparam int INDEX_W = 3;

  // register reset values
  localparam logic [REG_W-1:0]  MIN_RATE_RST   = REG_W'(100000);
  localparam logic [REG_W-1:0]  MAX_RATE_RST   = REG_W'(50000000);
  localparam logic [REG_W-1:0]  START_RATE_RST = REG_W'(1000000);
  localparam logic [TRIP_W-1:0] FAIL_TRIP_RST  = TRIP_W'(3);
  localparam logic [TRIP_W-1:0] OK_TRIP_RST    = TRIP_W'(8);

  // configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_MIN_RATE   = 3'd0,
    REG_MAX_RATE   = 3'd1,
    REG_START_RATE = 3'd2,
    REG_FAIL_TRIP  = 3'd3,
    REG_OK_TRIP    = 3'd4
  } cfg_index_t;

  // item kinds
  localparam logic MODE_REPORT  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef logic [RATE_BITS-1:0] rate_t;

  // start rate clamped into floor and ceiling, floor tested first
  function automatic rate_t clamp_start(rate_t lo, rate_t hi, rate_t st);
    rate_t r;
    if (st < lo) begin
      r = lo;
    end else if (st > hi) begin
      r = hi;
    end else begin
      r = st;
    end
    return r;
  endfunction

  // a trip setting of zero counts as one
  function automatic logic [TRIP_W-1:0] trip_of(logic [TRIP_W-1:0] t);
    return (t == '0) ? TRIP_W'(1) : t;
  endfunction

endpackage

FILE: rtl/link_clock_rate_backoff.sv
// An accepted item is registered in the input stage, then its result is held
//   in the output register. Throughput: one item per cycle while out_ready
//   does not hold back a report; the rate and streak update is a single
//   compare, shift and count step between the input and output registers.
// Restart items produce no result and never wait on the output register.
// Reset (rst, synchronous) loads the register defaults, the clamped start rate
//   of 1000000 Hz, clears both streaks and empties both stages.
module link_clock_rate_backoff (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic                                  crc_good,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lcrb_pkg::OUT_W-1:0]            clock_hz,
  input  logic                                  cfg_we,
  input  logic [lcrb_pkg::INDEX_W-1:0]          cfg_index,
  input  logic [lcrb_pkg::REG_W-1:0]            cfg_data
);

  // configuration registers
  logic [lcrb_pkg::REG_W-1:0]  min_rate_hz;
  logic [lcrb_pkg::REG_W-1:0]  max_rate_hz;
  logic [lcrb_pkg::REG_W-1:0]  start_rate_hz;
  logic [lcrb_pkg::TRIP_W-1:0] fail_trip_count;
  logic [lcrb_pkg::TRIP_W-1:0] ok_trip_count;

  // adaptation state
  lcrb_pkg::rate_t             rate_hz;
  lcrb_pkg::rate_t             rate_hz_next;
  logic [lcrb_pkg::TRIP_W-1:0] failure_streak;
  logic [lcrb_pkg::TRIP_W-1:0] failure_streak_next;
  logic [lcrb_pkg::TRIP_W-1:0] success_streak;
  logic [lcrb_pkg::TRIP_W-1:0] success_streak_next;

  // input stage
  logic s1_valid;
  logic s1_mode;
  logic s1_crc_good;
  logic advance;

  // working values
  lcrb_pkg::rate_t           lo;
  lcrb_pkg::rate_t           hi;
  lcrb_pkg::rate_t           st;
  lcrb_pkg::rate_t           down;
  logic [lcrb_pkg::RATE_BITS:0] up;
  logic [lcrb_pkg::TRIP_W-1:0] ok_inc;
  logic [lcrb_pkg::TRIP_W-1:0] fail_inc;

  assign lo = lcrb_pkg::RATE_BITS'(min_rate_hz);
  assign hi = lcrb_pkg::RATE_BITS'(max_rate_hz);
  assign st = lcrb_pkg::RATE_BITS'(start_rate_hz);

  // a restart always leaves the stage; a report needs room in the output register
  assign advance  = s1_valid && ((s1_mode == lcrb_pkg::MODE_RESTART) || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate_hz     <= lcrb_pkg::MIN_RATE_RST;
      max_rate_hz     <= lcrb_pkg::MAX_RATE_RST;
      start_rate_hz   <= lcrb_pkg::START_RATE_RST;
      fail_trip_count <= lcrb_pkg::FAIL_TRIP_RST;
      ok_trip_count   <= lcrb_pkg::OK_TRIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcrb_pkg::REG_MIN_RATE:   min_rate_hz     <= cfg_data;
        lcrb_pkg::REG_MAX_RATE:   max_rate_hz     <= cfg_data;
        lcrb_pkg::REG_START_RATE: start_rate_hz   <= cfg_data;
        lcrb_pkg::REG_FAIL_TRIP:  fail_trip_count <= lcrb_pkg::TRIP_W'(cfg_data);
        lcrb_pkg::REG_OK_TRIP:    ok_trip_count   <= lcrb_pkg::TRIP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode     <= mode;
      s1_crc_good <= crc_good;
    end
  end

  // next rate and streaks for the item in the input stage
  always_comb begin
    ok_inc              = success_streak + lcrb_pkg::TRIP_W'(1);
    fail_inc            = failure_streak + lcrb_pkg::TRIP_W'(1);
    up                  = {rate_hz, 1'b0};
    down                = rate_hz >> 1;
    rate_hz_next        = rate_hz;
    success_streak_next = success_streak;
    failure_streak_next = failure_streak;
    if (s1_mode == lcrb_pkg::MODE_RESTART) begin
      rate_hz_next        = lcrb_pkg::clamp_start(lo, hi, st);
      success_streak_next = '0;
      failure_streak_next = '0;
    end else if (s1_crc_good) begin
      failure_streak_next = '0;
      success_streak_next = ok_inc;
      if (ok_inc >= lcrb_pkg::trip_of(ok_trip_count)) begin
        success_streak_next = '0;
        // overflow past the rate width or above the ceiling clamps to the ceiling
        if (up[lcrb_pkg::RATE_BITS] || (up[lcrb_pkg::RATE_BITS-1:0] > hi)) begin
          rate_hz_next = hi;
        end else begin
          rate_hz_next = up[lcrb_pkg::RATE_BITS-1:0];
        end
      end
    end else begin
      success_streak_next = '0;
      failure_streak_next = fail_inc;
      if (fail_inc >= lcrb_pkg::trip_of(fail_trip_count)) begin
        failure_streak_next = '0;
        rate_hz_next        = (down < lo) ? lo : down;
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz        <= lcrb_pkg::clamp_start(lcrb_pkg::RATE_BITS'(lcrb_pkg::MIN_RATE_RST),
                                              lcrb_pkg::RATE_BITS'(lcrb_pkg::MAX_RATE_RST),
                                              lcrb_pkg::RATE_BITS'(lcrb_pkg::START_RATE_RST));
      success_streak <= '0;
      failure_streak <= '0;
    end else if (advance) begin
      rate_hz        <= rate_hz_next;
      success_streak <= success_streak_next;
      failure_streak <= failure_streak_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (s1_mode == lcrb_pkg::MODE_REPORT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s1_mode == lcrb_pkg::MODE_REPORT)) begin
      clock_hz <= lcrb_pkg::OUT_W'(rate_hz_next);
    end
  end

  // checks
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_mode == lcrb_pkg::MODE_RESTART)) |=>
      (success_streak == '0) && (failure_streak == '0))
    else $error("restart left a streak set");

  a_one_streak: assert property (@(posedge clk) disable iff (rst)
    !((success_streak != '0) && (failure_streak != '0)))
    else $error("both streaks nonzero");

  a_report_result: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_mode == lcrb_pkg::MODE_REPORT)) |=> out_valid)
    else $error("report item gave no result");

  a_rate_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(rate_hz))
    else $error("rate changed without an item");

endmodule

FILE: dv/lcrb_checker.sv
module lcrb_checker
  import lcrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic               crc_good,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [OUT_W-1:0]   clock_hz,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending
);

  // shadow copy of the configuration
  rate_t             floor_hz;
  rate_t             ceil_hz;
  rate_t             restart_hz;
  logic [TRIP_W-1:0] fail_limit;
  logic [TRIP_W-1:0] ok_limit;

  // shadow copy of the rate and the two streaks
  rate_t             rate_hz;
  logic [TRIP_W-1:0] fail_run;
  logic [TRIP_W-1:0] ok_run;

  // clock rates still owed by the block, oldest first
  logic [OUT_W-1:0]  owed_hz_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // start rate pulled into the floor..ceiling window, floor first
  function automatic rate_t reload_rate();
    rate_t r;
    r = restart_hz;
    if (restart_hz < floor_hz) begin
      r = floor_hz;
    end else if (restart_hz > ceil_hz) begin
      r = ceil_hz;
    end
    return r;
  endfunction

  // advance the shadow state by one item and queue the rate it reports
  task automatic advance_rate(input logic item_mode, input logic good);
    logic [RATE_BITS:0] doubled;
    rate_t              halved;
    logic [TRIP_W-1:0]  trip;
    if (item_mode == MODE_RESTART) begin
      rate_hz  = reload_rate();
      fail_run = '0;
      ok_run   = '0;
    end else begin
      if (good) begin
        fail_run = '0;
        ok_run   = ok_run + 1'b1;
        trip     = (ok_limit == '0) ? TRIP_W'(1) : ok_limit;
        if (ok_run >= trip) begin
          ok_run  = '0;
          doubled = {rate_hz, 1'b0};
          // overflow past the width or the ceiling pins to the ceiling
          if (doubled > {1'b0, ceil_hz}) begin
            rate_hz = ceil_hz;
          end else begin
            rate_hz = doubled[RATE_BITS-1:0];
          end
        end
      end else begin
        ok_run   = '0;
        fail_run = fail_run + 1'b1;
        trip     = (fail_limit == '0) ? TRIP_W'(1) : fail_limit;
        if (fail_run >= trip) begin
          fail_run = '0;
          halved   = rate_hz >> 1;
          if (halved < floor_hz) begin
            halved = floor_hz;
          end
          rate_hz = halved;
        end
      end
      owed_hz_q.push_back(OUT_W'(rate_hz));
    end
  endtask

  // watch config writes, accepted items and accepted results
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      floor_hz   = MIN_RATE_RST;
      ceil_hz    = MAX_RATE_RST;
      restart_hz = START_RATE_RST;
      fail_limit = FAIL_TRIP_RST;
      ok_limit   = OK_TRIP_RST;
      rate_hz    = reload_rate();
      fail_run   = '0;
      ok_run     = '0;
      owed_hz_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_RATE:   floor_hz   = cfg_data[RATE_BITS-1:0];
          REG_MAX_RATE:   ceil_hz    = cfg_data[RATE_BITS-1:0];
          REG_START_RATE: restart_hz = cfg_data[RATE_BITS-1:0];
          REG_FAIL_TRIP:  fail_limit = cfg_data[TRIP_W-1:0];
          REG_OK_TRIP:    ok_limit   = cfg_data[TRIP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_hz_q.size() == 0) begin
          $error("clock_hz: unexpected result, actual %0d", clock_hz);
          fail_count = fail_count + 1;
        end else begin
          want = owed_hz_q.pop_front();
          if (clock_hz !== want) begin
            $error("clock_hz mismatch: expected %0d actual %0d", want, clock_hz);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_rate(mode, crc_good);
      end
    end
    pending = owed_hz_q.size();
  end

endmodule

FILE: dv/tb_link_clock_rate_backoff.sv
module tb_link_clock_rate_backoff;
  import lcrb_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 105;
  localparam logic [REG_W-1:0] RATE_FULL = {REG_W{1'b1}};

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic               crc_good;
  logic               out_valid;
  logic               out_ready;
  logic [OUT_W-1:0]   clock_hz;
  logic               cfg_we;
  logic [INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int cycles;
  int rx_stall_left;
  bit rx_stalls_on;
  bit tx_gaps_on;

  // trip settings as last written, used to shape runs of outcomes
  int cur_ok_trip;
  int cur_fail_trip;

  link_clock_rate_backoff dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .crc_good  (crc_good),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .clock_hz  (clock_hz),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcrb_checker rate_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .crc_good   (crc_good),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .clock_hz   (clock_hz),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run-length guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("link_clock_rate_backoff regression: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_ready     <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready     <= 1'b0;
      rx_stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // offer one item and hold it until taken
  task automatic send_item(input logic item_mode, input logic good);
    in_valid <= 1'b1;
    mode     <= item_mode;
    crc_good <= good;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender idle time with junk on the payload
  task automatic idle_gap();
    int n;
    n = tx_gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      mode     <= 1'($urandom);
      crc_good <= 1'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_and_idle(input logic item_mode, input logic good);
    send_item(item_mode, good);
    idle_gap();
  endtask

  // stop sending and wait out every owed result plus the restart latency
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_trips(input logic [TRIP_W-1:0] fail_t, input logic [TRIP_W-1:0] ok_t);
    write_reg(REG_FAIL_TRIP, REG_W'(fail_t));
    write_reg(REG_OK_TRIP, REG_W'(ok_t));
    cur_fail_trip = (fail_t == 0) ? 1 : int'(fail_t);
    cur_ok_trip   = (ok_t == 0) ? 1 : int'(ok_t);
  endtask

  function automatic logic [REG_W-1:0] pick_rate_reg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return RATE_FULL;
      2:       return REG_W'($urandom_range(1, 255));
      3:       return REG_W'($urandom);
      4:       return REG_W'(1) << $urandom_range(0, REG_W - 1);
      default: return REG_W'($urandom_range(1000, 100000000));
    endcase
  endfunction

  function automatic logic [TRIP_W-1:0] pick_trip();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 16) return TRIP_W'($urandom_range(1, 4));
    return TRIP_W'($urandom_range(5, 12));
  endfunction

  // one random setting followed by runs of outcomes shaped around the trips
  task automatic run_phase(input int n_items, input bit mid_drain);
    int  left;
    int  len;
    int  trip;
    int  r;
    bit  good;
    left = n_items;
    write_reg(REG_MIN_RATE, pick_rate_reg());
    write_reg(REG_MAX_RATE, pick_rate_reg());
    write_reg(REG_START_RATE, pick_rate_reg());
    set_trips(pick_trip(), pick_trip());
    // unmapped index, must change nothing
    if ($urandom_range(0, 2) == 0) begin
      write_reg(INDEX_W'($urandom_range(5, 7)), REG_W'($urandom));
    end
    send_and_idle(MODE_RESTART, 1'($urandom));
    left = left - 1;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_and_idle(MODE_RESTART, 1'($urandom));
        left = left - 1;
      end else if (r < 16) begin
        send_and_idle(MODE_REPORT, 1'($urandom));
        left = left - 1;
      end else begin
        good = ($urandom_range(0, 99) < 55);
        trip = good ? cur_ok_trip : cur_fail_trip;
        len  = ($urandom_range(0, 9) < 7) ? trip : $urandom_range(1, trip + 1);
        if (len > left) len = left;
        repeat (len) send_and_idle(MODE_REPORT, good);
        left = left - len;
      end
      // sender holds off until the block has caught up
      if (mid_drain && left < n_items / 2) begin
        drain();
        mid_drain = 1'b0;
      end
    end
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_REPORT;
    crc_good      = 1'b0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MIN_RATE;
    cfg_data      = '0;
    rx_stall_left = 0;
    rx_stalls_on  = 1'b0;
    tx_gaps_on    = 1'b0;
    cur_ok_trip   = int'(OK_TRIP_RST);
    cur_fail_trip = int'(FAIL_TRIP_RST);
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: one doubling, one halving, restart, streak clearing
    repeat (8) send_and_idle(MODE_REPORT, 1'b1);
    repeat (3) send_and_idle(MODE_REPORT, 1'b0);
    send_and_idle(MODE_RESTART, 1'b1);
    send_and_idle(MODE_REPORT, 1'b0);
    send_and_idle(MODE_REPORT, 1'b1);
    send_and_idle(MODE_RESTART, 1'b0);
    drain();

    // full-scale window with zero trips: doubling overflow, trip of zero
    write_reg(REG_MIN_RATE, '0);
    write_reg(REG_MAX_RATE, RATE_FULL);
    write_reg(REG_START_RATE, RATE_FULL);
    set_trips('0, '0);
    send_and_idle(MODE_RESTART, 1'b1);
    send_and_idle(MODE_REPORT, 1'b1);
    send_and_idle(MODE_REPORT, 1'b0);
    send_and_idle(MODE_REPORT, 1'b0);
    drain();
    write_reg(REG_START_RATE, '0);
    send_and_idle(MODE_RESTART, 1'b0);
    send_and_idle(MODE_REPORT, 1'b1);
    drain();

    // floor above ceiling, start below floor
    write_reg(REG_MIN_RATE, REG_W'(28'h0800000));
    write_reg(REG_MAX_RATE, REG_W'(28'h100));
    write_reg(REG_START_RATE, REG_W'(28'h50));
    send_and_idle(MODE_RESTART, 1'b1);
    send_and_idle(MODE_REPORT, 1'b1);
    send_and_idle(MODE_REPORT, 1'b0);
    drain();

    // start above ceiling
    write_reg(REG_MIN_RATE, REG_W'(10));
    write_reg(REG_MAX_RATE, REG_W'(1000));
    write_reg(REG_START_RATE, REG_W'(5000));
    send_and_idle(MODE_RESTART, 1'b0);
    send_and_idle(MODE_REPORT, 1'b1);
    drain();

    // random settings, varying the idling on each side
    for (int p = 0; p < PHASES; p++) begin
      tx_gaps_on   = (p != 0) && (p != 2);
      rx_stalls_on = (p != 0) && (p != 3);
      run_phase(PHASE_ITEMS, (p == 1) || (p == 4));
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("link_clock_rate_backoff regression: pass");
    end else begin
      $display("link_clock_rate_backoff regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lcrb_pkg.sv
rtl/link_clock_rate_backoff.sv
dv/lcrb_checker.sv
dv/tb_link_clock_rate_backoff.sv
